@@ design/jgs_pkg.sv @@
package jgs_pkg;

	// Grid geometry and data widths.
	localparam int MAX_DIM   = 64;
	localparam int IDX_W     = $clog2(MAX_DIM);
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int DIM_W     = IDX_W + 1;
	localparam int DATA_W    = 32;
	localparam int SUM_W     = DATA_W + 2;
	localparam int CHANGE_W  = 48;
	localparam int TOL_W     = 31;
	localparam int SQ_W      = 2 * IDX_W;
	localparam int THRESH_W  = TOL_W + SQ_W;
	localparam int LIMIT_W   = 20;

	// Operation codes carried in tuser.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SOLVE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_GRID  = 2'd0;
	localparam logic [1:0] REG_TOL   = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	// Datapath operations.
	localparam logic [2:0] DP_NOP    = 3'd0;
	localparam logic [2:0] DP_CENTER = 3'd1;
	localparam logic [2:0] DP_FIRST  = 3'd2;
	localparam logic [2:0] DP_ADD    = 3'd3;
	localparam logic [2:0] DP_APPLY  = 3'd4;
	localparam logic [2:0] DP_CLEAR  = 3'd5;
	localparam logic [2:0] DP_SQUARE = 3'd6;
	localparam logic [2:0] DP_THRESH = 3'd7;

	typedef struct packed {
		logic [2:0]        op;
		logic              wr_a;
		logic              wr_b;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic              rd_src;
		logic [IDX_W-1:0]  dim_m1;
	} dp_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] rd_data;
		logic              converged;
		logic              change_zero;
	} dp_stat_t;

endpackage

@@ design/jgs_ram.sv @@
module jgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/jgs_datapath.sv @@
module jgs_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jgs_pkg::dp_cmd_t               cmd,
	input  logic [jgs_pkg::DATA_W-1:0]     host_value,
	input  logic [jgs_pkg::TOL_W-1:0]      tolerance,
	output jgs_pkg::dp_stat_t              stat
);

	logic [jgs_pkg::DATA_W-1:0]   a_rdata;
	logic [jgs_pkg::DATA_W-1:0]   b_rdata;
	logic [jgs_pkg::DATA_W-1:0]   rdata;
	logic [jgs_pkg::DATA_W-1:0]   wdata;
	logic [jgs_pkg::DATA_W-1:0]   center_q;
	logic signed [jgs_pkg::SUM_W-1:0] sum_q;
	logic [jgs_pkg::CHANGE_W-1:0] change_q;
	logic [jgs_pkg::SQ_W-1:0]     square_q;
	logic [jgs_pkg::THRESH_W-1:0] thresh_q;
	logic [jgs_pkg::DATA_W-1:0]   quarter;
	logic signed [jgs_pkg::DATA_W:0] diff;
	logic [jgs_pkg::DATA_W:0]     abs_diff;

	// Two banks; both are read at the same address and one is selected.
	jgs_ram #(.WIDTH(jgs_pkg::DATA_W), .DEPTH(jgs_pkg::MAX_DIM * jgs_pkg::MAX_DIM)) u_bank_a (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (cmd.waddr),
		.wdata (wdata),
		.raddr (cmd.raddr),
		.rdata (a_rdata)
	);

	jgs_ram #(.WIDTH(jgs_pkg::DATA_W), .DEPTH(jgs_pkg::MAX_DIM * jgs_pkg::MAX_DIM)) u_bank_b (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (cmd.waddr),
		.wdata (wdata),
		.raddr (cmd.raddr),
		.rdata (b_rdata)
	);

	assign rdata = cmd.rd_src ? b_rdata : a_rdata;

	// The floor of a quarter is an arithmetic shift by two.
	assign quarter  = sum_q[jgs_pkg::SUM_W-1:2];
	assign diff     = $signed({quarter[jgs_pkg::DATA_W-1], quarter})
	                - $signed({center_q[jgs_pkg::DATA_W-1], center_q});
	assign abs_diff = diff[jgs_pkg::DATA_W] ? (jgs_pkg::DATA_W+1)'(-diff)
	                                        : (jgs_pkg::DATA_W+1)'(diff);
	assign wdata    = (cmd.op == jgs_pkg::DP_APPLY) ? quarter : host_value;

	// Stencil accumulation, change sum and threshold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			sum_q    <= '0;
			change_q <= '0;
			square_q <= '0;
			thresh_q <= '0;
		end else begin
			unique case (cmd.op)
				jgs_pkg::DP_CENTER: center_q <= rdata;
				jgs_pkg::DP_FIRST:  sum_q <= jgs_pkg::SUM_W'($signed(rdata));
				jgs_pkg::DP_ADD:    sum_q <= sum_q + jgs_pkg::SUM_W'($signed(rdata));
				jgs_pkg::DP_APPLY:  change_q <= change_q + jgs_pkg::CHANGE_W'(abs_diff);
				jgs_pkg::DP_CLEAR:  change_q <= '0;
				jgs_pkg::DP_SQUARE: square_q <= jgs_pkg::SQ_W'(cmd.dim_m1) * jgs_pkg::SQ_W'(cmd.dim_m1);
				jgs_pkg::DP_THRESH: begin
					thresh_q <= jgs_pkg::THRESH_W'(tolerance) * jgs_pkg::THRESH_W'(square_q);
					change_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign stat.rd_data     = rdata;
	assign stat.converged   = change_q < jgs_pkg::CHANGE_W'(thresh_q);
	assign stat.change_zero = (change_q == '0);

endmodule

@@ design/jgs_ctrl.sv @@
module jgs_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [1:0]                     in_op,
	input  logic [jgs_pkg::IDX_W-1:0]      in_row,
	input  logic [jgs_pkg::IDX_W-1:0]      in_col,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [jgs_pkg::DATA_W-1:0]     out_value,
	output logic [jgs_pkg::LIMIT_W-1:0]    out_sweeps,
	output logic [1:0]                     out_status,
	input  logic [jgs_pkg::DIM_W-1:0]      grid_size,
	input  logic [jgs_pkg::LIMIT_W-1:0]    iteration_limit,
	output jgs_pkg::dp_cmd_t               cmd,
	input  jgs_pkg::dp_stat_t              stat
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_SQ    = 3'd2;
	localparam logic [2:0] S_THR   = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;
	localparam logic [2:0] S_END   = 3'd5;

	localparam logic [2:0] PH_LAST = 3'd6;

	logic [2:0]                    state_q;
	logic [2:0]                    phase_q;
	logic [jgs_pkg::IDX_W-1:0]     row_q;
	logic [jgs_pkg::IDX_W-1:0]     col_q;
	logic                          cur_q;
	logic [jgs_pkg::LIMIT_W-1:0]   count_q;
	logic [jgs_pkg::LIMIT_W-1:0]   count_inc;
	logic [jgs_pkg::LIMIT_W-1:0]   limit_eff;
	logic [jgs_pkg::DIM_W-1:0]     dim;
	logic [jgs_pkg::DIM_W-1:0]     dim_m2;
	logic                          in_range;
	logic                          accept;
	logic                          sweep_more;
	logic                          last_col;
	logic                          last_row;
	logic                          result_set;

	// Effective grid size and iteration limit.
	always_comb begin
		if (grid_size < jgs_pkg::DIM_W'(3)) begin
			dim = jgs_pkg::DIM_W'(3);
		end else if (grid_size > jgs_pkg::DIM_W'(jgs_pkg::MAX_DIM)) begin
			dim = jgs_pkg::DIM_W'(jgs_pkg::MAX_DIM);
		end else begin
			dim = grid_size;
		end
	end

	assign dim_m2     = dim - jgs_pkg::DIM_W'(2);
	assign limit_eff  = (iteration_limit == '0) ? jgs_pkg::LIMIT_W'(1) : iteration_limit;
	assign in_range   = ({1'b0, in_row} < dim) && ({1'b0, in_col} < dim);
	assign s_tready   = (state_q == S_IDLE) && (!m_tvalid || m_tready);
	assign accept     = s_tvalid && s_tready;
	assign count_inc  = count_q + jgs_pkg::LIMIT_W'(1);
	assign last_col   = ({1'b0, col_q} == dim_m2);
	assign last_row   = ({1'b0, row_q} == dim_m2);
	assign sweep_more = !stat.converged && !stat.change_zero && (count_inc < limit_eff);

	// A result beat is loaded in this cycle.
	assign result_set = (accept && (in_op != jgs_pkg::OP_SOLVE)
	                     && !(in_op == jgs_pkg::OP_READ && in_range))
	                  || (state_q == S_READ)
	                  || (state_q == S_END && !sweep_more);

	// Commands to the datapath.
	always_comb begin
		cmd        = '0;
		cmd.op     = jgs_pkg::DP_NOP;
		cmd.waddr  = {in_row, in_col};
		cmd.raddr  = {in_row, in_col};
		cmd.rd_src = cur_q;
		cmd.dim_m1 = jgs_pkg::IDX_W'(dim - jgs_pkg::DIM_W'(1));
		unique case (state_q)
			S_IDLE: begin
				if (accept && in_op == jgs_pkg::OP_WRITE && in_range) begin
					cmd.wr_a = 1'b1;
					cmd.wr_b = 1'b1;
				end
			end
			S_SQ:  cmd.op = jgs_pkg::DP_SQUARE;
			S_THR: cmd.op = jgs_pkg::DP_THRESH;
			S_SWEEP: begin
				// Reads go out in phases 0 to 4; data lands one phase later.
				unique case (phase_q)
					3'd0: cmd.raddr = {row_q, col_q};
					3'd1: begin
						cmd.raddr = {row_q - jgs_pkg::IDX_W'(1), col_q};
						cmd.op    = jgs_pkg::DP_CENTER;
					end
					3'd2: begin
						cmd.raddr = {row_q + jgs_pkg::IDX_W'(1), col_q};
						cmd.op    = jgs_pkg::DP_FIRST;
					end
					3'd3: begin
						cmd.raddr = {row_q, col_q + jgs_pkg::IDX_W'(1)};
						cmd.op    = jgs_pkg::DP_ADD;
					end
					3'd4: begin
						cmd.raddr = {row_q, col_q - jgs_pkg::IDX_W'(1)};
						cmd.op    = jgs_pkg::DP_ADD;
					end
					3'd5: cmd.op = jgs_pkg::DP_ADD;
					default: begin
						cmd.op    = jgs_pkg::DP_APPLY;
						cmd.waddr = {row_q, col_q};
						cmd.wr_a  = cur_q;
						cmd.wr_b  = !cur_q;
					end
				endcase
			end
			S_END: begin
				if (sweep_more) begin
					cmd.op = jgs_pkg::DP_CLEAR;
				end
			end
			default: ;
		endcase
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			phase_q    <= '0;
			row_q      <= '0;
			col_q      <= '0;
			cur_q      <= 1'b0;
			count_q    <= '0;
			m_tvalid   <= 1'b0;
			out_value  <= '0;
			out_sweeps <= '0;
			out_status <= jgs_pkg::ST_OK;
		end else begin
			if (result_set) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_value  <= '0;
						out_sweeps <= count_q;
						unique case (in_op)
							jgs_pkg::OP_WRITE: begin
								out_status <= in_range ? jgs_pkg::ST_OK : jgs_pkg::ST_RANGE;
							end
							jgs_pkg::OP_READ: begin
								if (in_range) begin
									state_q <= S_READ;
								end else begin
									out_status <= jgs_pkg::ST_RANGE;
								end
							end
							jgs_pkg::OP_SOLVE: begin
								count_q <= '0;
								state_q <= S_SQ;
							end
							default: begin
								out_status <= jgs_pkg::ST_OK;
							end
						endcase
					end
				end
				S_READ: begin
					out_value  <= stat.rd_data;
					out_status <= jgs_pkg::ST_OK;
					state_q    <= S_IDLE;
				end
				S_SQ: state_q <= S_THR;
				S_THR: begin
					row_q   <= jgs_pkg::IDX_W'(1);
					col_q   <= jgs_pkg::IDX_W'(1);
					phase_q <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (phase_q == PH_LAST) begin
						phase_q <= '0;
						if (last_col) begin
							col_q <= jgs_pkg::IDX_W'(1);
							if (last_row) begin
								state_q <= S_END;
							end else begin
								row_q <= row_q + jgs_pkg::IDX_W'(1);
							end
						end else begin
							col_q <= col_q + jgs_pkg::IDX_W'(1);
						end
					end else begin
						phase_q <= phase_q + 3'd1;
					end
				end
				S_END: begin
					cur_q <= !cur_q;
					if (sweep_more) begin
						count_q <= count_inc;
						row_q   <= jgs_pkg::IDX_W'(1);
						col_q   <= jgs_pkg::IDX_W'(1);
						state_q <= S_SWEEP;
					end else begin
						// A sweep that changes nothing would repeat forever, so unless it converged it is reported as run to the limit.
						priority if (stat.converged) begin
							count_q    <= count_inc;
							out_sweeps <= count_inc;
							out_status <= jgs_pkg::ST_OK;
						end else if (stat.change_zero) begin
							count_q    <= limit_eff;
							out_sweeps <= limit_eff;
							out_status <= jgs_pkg::ST_LIMIT;
						end else begin
							count_q    <= count_inc;
							out_sweeps <= count_inc;
							out_status <= jgs_pkg::ST_LIMIT;
						end
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ design/jacobi_grid_solver_unit.sv @@
// Jacobi solver for the 2-D Laplace equation on a square grid of up to 64 by 64 signed
// Q16.16 points, held in two 4096-entry banks. A write or an out-of-range access is answered
// straight from the idle state and a read from a read state, since the bank read port is
// registered. A solve runs sweeps until the summed absolute change falls below the tolerance
// times (grid_size-1)^2, a sweep changes nothing or the iteration limit is hit; each interior
// point's center and four neighbors are fetched one at a time through the single read port
// of the source bank. One beat is answered for every input beat.
module jacobi_grid_solver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // row [5:0], col [11:6], value [43:12], zero fill
	input  logic [1:0]  s_tuser,  // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // read_value [31:0], sweeps_done [51:32], status [53:52], zero fill
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [jgs_pkg::DIM_W-1:0]   grid_size_q;
	logic [jgs_pkg::TOL_W-1:0]   tolerance_q;
	logic [jgs_pkg::LIMIT_W-1:0] limit_q;
	logic [jgs_pkg::DATA_W-1:0]  out_value;
	logic [jgs_pkg::LIMIT_W-1:0] out_sweeps;
	logic [1:0]                  out_status;
	jgs_pkg::dp_cmd_t            cmd;
	jgs_pkg::dp_stat_t           stat;

	// Configuration registers.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= jgs_pkg::DIM_W'(64);
			tolerance_q <= jgs_pkg::TOL_W'(7);
			limit_q     <= '1;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				jgs_pkg::REG_GRID:  grid_size_q <= pwdata[jgs_pkg::DIM_W-1:0];
				jgs_pkg::REG_TOL:   tolerance_q <= pwdata[jgs_pkg::TOL_W-1:0];
				jgs_pkg::REG_LIMIT: limit_q     <= pwdata[jgs_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			jgs_pkg::REG_GRID:  prdata = 32'(grid_size_q);
			jgs_pkg::REG_TOL:   prdata = 32'(tolerance_q);
			jgs_pkg::REG_LIMIT: prdata = 32'(limit_q);
			default:            prdata = '0;
		endcase
	end

	jgs_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.in_op           (s_tuser),
		.in_row          (s_tdata[5:0]),
		.in_col          (s_tdata[11:6]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.out_value       (out_value),
		.out_sweeps      (out_sweeps),
		.out_status      (out_status),
		.grid_size       (grid_size_q),
		.iteration_limit (limit_q),
		.cmd             (cmd),
		.stat            (stat)
	);

	jgs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.host_value (s_tdata[43:12]),
		.tolerance  (tolerance_q),
		.stat       (stat)
	);

	assign m_tdata = {2'b00, out_status, out_sweeps, out_value};

	// A write beat is answered in the very next cycle.
	a_write_answer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == jgs_pkg::OP_WRITE |=> m_tvalid)
		else $error("write beat not answered in the next cycle");

	// Only a successful read carries a nonzero value.
	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[53:52] != jgs_pkg::ST_OK |-> m_tdata[31:0] == '0)
		else $error("nonzero read value with failing status");

	// The status field never holds the unused code.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[53:52] <= jgs_pkg::ST_LIMIT)
		else $error("unused status code on the result");

endmodule

@@ tb/jacobi_result_checker.sv @@
// Watches both stream channels and the register port, keeps its own copy of the grid banks
// and predicts every answer beat of the Jacobi solver.
module jacobi_result_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,  // row [5:0], col [11:6], value [43:12], zero fill
	input  logic [1:0]  s_tuser,  // op [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,  // read_value [31:0], sweeps_done [51:32], status [53:52]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output int          answers_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] sweeps;
		logic [31:0] read_value;
	} answer_t;

	answer_t     expected_answers[$];
	logic [31:0] grid_banks[2][jgs_pkg::MAX_DIM*jgs_pkg::MAX_DIM];
	bit          live_bank;
	logic [19:0] sweep_total;
	logic [6:0]  grid_reg;
	logic [30:0] tol_reg;
	logic [19:0] limit_reg;

	function automatic int unsigned active_dim();
		if (grid_reg < 3)
			return 3;
		if (grid_reg > jgs_pkg::MAX_DIM)
			return jgs_pkg::MAX_DIM;
		return grid_reg;
	endfunction

	// Runs sweeps on the ping-pong banks and returns the solve status.
	function automatic logic [1:0] run_sweeps(int unsigned dim);
		longint unsigned thresh;
		longint unsigned change;
		longint          s;
		longint          q;
		longint          d;
		int unsigned     k;
		int unsigned     cap;
		int unsigned     count;
		thresh = longint'(tol_reg) * (dim - 1) * (dim - 1);
		cap = (limit_reg == 0) ? 1 : limit_reg;
		count = 0;
		forever begin
			change = 0;
			for (int unsigned i = 1; i + 1 < dim; i++) begin
				for (int unsigned j = 1; j + 1 < dim; j++) begin
					k = i * jgs_pkg::MAX_DIM + j;
					s = longint'($signed(grid_banks[live_bank][k - jgs_pkg::MAX_DIM]))
						+ longint'($signed(grid_banks[live_bank][k + jgs_pkg::MAX_DIM]))
						+ longint'($signed(grid_banks[live_bank][k + 1]))
						+ longint'($signed(grid_banks[live_bank][k - 1]));
					q = s >>> 2;
					d = q - longint'($signed(grid_banks[live_bank][k]));
					change += (d < 0) ? -d : d;
					grid_banks[!live_bank][k] = q[31:0];
				end
			end
			live_bank = !live_bank;
			count++;
			sweep_total = count;
			if (change < thresh)
				return jgs_pkg::ST_OK;
			if (change == 0) begin
				count = cap;
				sweep_total = cap;
			end
			if (count >= cap)
				return jgs_pkg::ST_LIMIT;
		end
	endfunction

	function automatic answer_t predict_answer(logic [1:0] op, logic [5:0] row, logic [5:0] col,
			logic [31:0] value);
		answer_t     a;
		int unsigned dim;
		int unsigned k;
		dim = active_dim();
		a = '0;
		k = row * jgs_pkg::MAX_DIM + col;
		if (op == jgs_pkg::OP_WRITE || op == jgs_pkg::OP_READ) begin
			if (row >= dim || col >= dim) begin
				a.status = jgs_pkg::ST_RANGE;
			end else if (op == jgs_pkg::OP_WRITE) begin
				grid_banks[0][k] = value;
				grid_banks[1][k] = value;
			end else begin
				a.read_value = grid_banks[live_bank][k];
			end
		end else if (op == jgs_pkg::OP_SOLVE) begin
			a.status = run_sweeps(dim);
		end
		a.sweeps = sweep_total;
		return a;
	endfunction

	// Predict on accepted input beats, compare on accepted output beats.
	always @(posedge clk or negedge arst_n) begin
		answer_t got;
		answer_t want;
		if (!arst_n) begin
			live_bank = 0;
			sweep_total = '0;
			grid_reg = 7'd64;
			tol_reg = 31'd7;
			limit_reg = 20'hFFFFF;
			fail_count <= 0;
			pending <= 0;
			answers_seen <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					jgs_pkg::REG_GRID:  grid_reg = pwdata[6:0];
					jgs_pkg::REG_TOL:   tol_reg = pwdata[30:0];
					jgs_pkg::REG_LIMIT: limit_reg = pwdata[19:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_answers.push_back(predict_answer(s_tuser, s_tdata[5:0], s_tdata[11:6],
					s_tdata[43:12]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[53:0];
				answers_seen <= answers_seen + 1;
				if (expected_answers.size() == 0) begin
					$display("%0t: answer beat with none expected: %h", $realtime, got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_answers.pop_front();
					if (got.read_value !== want.read_value || got.sweeps !== want.sweeps
							|| got.status !== want.status) begin
						$display({"%0t: mismatch read_value exp %h got %h, ",
							"sweeps exp %0d got %0d, status exp %0d got %0d"},
							$realtime, want.read_value, got.read_value, want.sweeps, got.sweeps,
							want.status, got.status);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_answers.size();
		end
	end

endmodule

@@ tb/jacobi_grid_solver_unit_test.sv @@
// Drives points, solves and reads into the solver under changing grid settings.
module jacobi_grid_solver_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 400000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [55:0] m_tdata;
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending;
	int answers_seen;
	int send_idle = 13;
	int recv_idle = 61;
	int items_sent = 0;
	int solves_sent = 0;
	int stall_cycles = 0;
	int dim_now = 64;
	bit loaded[jgs_pkg::MAX_DIM*jgs_pkg::MAX_DIM];

	jacobi_grid_solver_unit dut (.*);

	jacobi_result_checker u_checker (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .pending, .answers_seen
	);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// Receiver back-pressure.
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	// Watchdog on cycles where no beat moves on any port.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(logic [1:0] op, int row, int col, logic [31:0] value);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= op;
		s_tdata <= {4'b0, value, col[5:0], row[5:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
		if (op == jgs_pkg::OP_SOLVE)
			solves_sent++;
		if (op == jgs_pkg::OP_WRITE && row < dim_now && col < dim_now)
			loaded[row * jgs_pkg::MAX_DIM + col] = 1;
	endtask

	// Waits until every answer has come back and the block has settled.
	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 0;
		penable <= 0;
		if (idx == jgs_pkg::REG_GRID)
			dim_now = (data[6:0] < 3) ? 3 : (data[6:0] > jgs_pkg::MAX_DIM) ? jgs_pkg::MAX_DIM
				: data[6:0];
	endtask

	// Fills the whole active grid: 0 random, 1 constant, 2 narrow range.
	task automatic load_grid(int mode);
		logic [31:0] base;
		base = $urandom;
		for (int r = 0; r < dim_now; r++)
			for (int c = 0; c < dim_now; c++)
				send(jgs_pkg::OP_WRITE, r, c, (mode == 0) ? $urandom :
					(mode == 1) ? base : $urandom_range(0, 32'h0003_0000));
	endtask

	function automatic bit grid_full();
		for (int r = 0; r < dim_now; r++)
			for (int c = 0; c < dim_now; c++)
				if (!loaded[r * jgs_pkg::MAX_DIM + c])
					return 0;
		return 1;
	endfunction

	task automatic random_segment(int count);
		int pick;
		int r;
		int c;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			r = $urandom_range(dim_now - 1);
			c = $urandom_range(dim_now - 1);
			if (pick < 40) begin
				send(jgs_pkg::OP_WRITE, r, c, $urandom);
			end else if (pick < 75) begin
				if (loaded[r * jgs_pkg::MAX_DIM + c])
					send(jgs_pkg::OP_READ, r, c, $urandom);
			end else if (pick < 85) begin
				if (dim_now < jgs_pkg::MAX_DIM)
					send($urandom_range(1) ? jgs_pkg::OP_READ : jgs_pkg::OP_WRITE,
						$urandom_range(dim_now, 63), $urandom_range(63), $urandom);
			end else if (pick < 90) begin
				send(jgs_pkg::OP_SPARE, $urandom_range(63), $urandom_range(63), $urandom);
			end else if (dim_now <= 8 && grid_full()) begin
				send(jgs_pkg::OP_SOLVE, $urandom_range(63), $urandom_range(63), $urandom);
			end
		end
	endtask

	initial begin
		logic [31:0] tol_pick;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes at the reset grid size.
		send(jgs_pkg::OP_WRITE, 0, 0, 32'h7FFF_FFFF);
		send(jgs_pkg::OP_WRITE, 63, 63, 32'h8000_0000);
		send(jgs_pkg::OP_READ, 0, 0, '0);
		send(jgs_pkg::OP_READ, 63, 63, '0);
		send(jgs_pkg::OP_SPARE, 63, 63, 32'hFFFF_FFFF);
		drain();
		reg_write(jgs_pkg::REG_GRID, 32'd3);
		send(jgs_pkg::OP_WRITE, 3, 0, 32'h1);
		send(jgs_pkg::OP_READ, 0, 5, '0);
		// A constant grid never changes, so a zero tolerance runs out the limit at once.
		load_grid(1);
		drain();
		reg_write(jgs_pkg::REG_TOL, 32'd0);
		reg_write(jgs_pkg::REG_LIMIT, 32'hFFFFF);
		send(jgs_pkg::OP_SOLVE, 0, 0, '0);
		send(jgs_pkg::OP_WRITE, 1, 1, 32'h8000_0000);
		drain();
		// Huge tolerance with a zero limit: converges on the first sweep.
		reg_write(jgs_pkg::REG_TOL, 32'hFFFF_FFFF);
		reg_write(jgs_pkg::REG_LIMIT, 32'd0);
		send(jgs_pkg::OP_SOLVE, 0, 0, '0);
		send(jgs_pkg::OP_READ, 1, 1, '0);
		drain();
		reg_write(jgs_pkg::REG_TOL, 32'd0);
		reg_write(jgs_pkg::REG_LIMIT, 32'd1);
		send(jgs_pkg::OP_WRITE, 1, 1, 32'h7FFF_FFFF);
		send(jgs_pkg::OP_SOLVE, 0, 0, '0);
		send(jgs_pkg::OP_READ, 1, 1, '0);
		drain();
		reg_write(jgs_pkg::REG_GRID, 32'd0);
		send(jgs_pkg::OP_READ, 2, 2, '0);
		drain();
		reg_write(jgs_pkg::REG_GRID, 32'd127);
		send(jgs_pkg::OP_WRITE, 63, 0, 32'h5555_AAAA);
		send(jgs_pkg::OP_READ, 63, 0, '0);

		// Random phases with the three idle patterns.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 13 : (phase == 1) ? 61 : 0;
			recv_idle = (phase == 0) ? 61 : (phase == 1) ? 13 : 0;
			for (int seg = 0; seg < 5; seg++) begin
				drain();
				if (seg == 4)
					reg_write(jgs_pkg::REG_GRID, $urandom_range(9, 127));
				else
					reg_write(jgs_pkg::REG_GRID, $urandom_range(0, 8));
				case ($urandom_range(3))
					0: tol_pick = 32'd0;
					1: tol_pick = $urandom_range(1, 32'h0000_4000);
					2: tol_pick = 32'h7FFF_FFFF;
					default: tol_pick = $urandom;
				endcase
				reg_write(jgs_pkg::REG_TOL, tol_pick);
				reg_write(jgs_pkg::REG_LIMIT, $urandom_range(0, 12));
				if (dim_now <= 8)
					load_grid($urandom_range(2));
				random_segment(30);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Covered %0d input beats including %0d solves; %0d answer beats checked.",
			items_sent, solves_sent, answers_seen);
		$display("Grid sizes 3 to 64, tolerance and limit extremes, range errors, unused op.");
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ jacobi_grid_solver_unit.f @@
design/jgs_pkg.sv
design/jgs_ram.sv
design/jgs_datapath.sv
design/jgs_ctrl.sv
design/jacobi_grid_solver_unit.sv
tb/jacobi_result_checker.sv
tb/jacobi_grid_solver_unit_test.sv
